// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps

package rrts_pkg;

    // action codes of an input transaction
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // register indexes on the configuration port
    localparam logic REG_QUANTUM    = 1'b0;
    localparam logic REG_TASK_COUNT = 1'b1;

    // datapath phase selected by the controller
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_EXEC   = 2'd1;
    localparam logic [1:0] MODE_SCAN   = 2'd2;
    localparam logic [1:0] MODE_COMMIT = 2'd3;

    localparam logic [15:0] TIME_MAX  = 16'hFFFF;
    localparam logic [7:0]  SLICE_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  slot;
        logic [7:0]  burst;
        logic [15:0] arrival;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  ran_slot;
        logic        idle;
        logic        completed;
        logic [15:0] completion_time;
        logic        all_done;
    } t_out_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       capture;
        logic       commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic cont_ok;
        logic n_zero;
        logic scan_hit;
        logic scan_last;
    } t_dp_status;

endpackage

// ===== rtl/rrts_if.sv =====
`timescale 1ns / 1ps

// input channel
interface rrts_in_if;
    import rrts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface rrts_out_if;
    import rrts_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rrts_ctrl.sv =====
`timescale 1ns / 1ps

module rrts_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  rrts_pkg::t_dp_status i_status,
    output rrts_pkg::t_dp_cmd    o_cmd
);
    import rrts_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd.mode    = MODE_NONE;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.mode = MODE_EXEC;
                if (i_status.is_tick && !i_status.cont_ok && !i_status.n_zero) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_SCAN: begin
                o_cmd.mode = MODE_SCAN;
                if (i_status.scan_hit || i_status.scan_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.mode   = MODE_COMMIT;
                o_cmd.commit = out_free;
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/rrts_dp.sv =====
`timescale 1ns / 1ps

module rrts_dp #(
    parameter int MAX_TASKS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_quantum,
    input  logic [3:0]           i_task_count,
    input  rrts_pkg::t_in_item   i_item,
    input  rrts_pkg::t_dp_cmd    i_cmd,
    output rrts_pkg::t_dp_status o_status,
    output rrts_pkg::t_out_item  o_result
);
    import rrts_pkg::*;

    // only eight entries can ever be loaded; entries past them stay empty
    localparam int STORE     = (MAX_TASKS < 8) ? MAX_TASKS : 8;
    localparam int SW        = $clog2(STORE);
    localparam int IDX_LIMIT = (MAX_TASKS < 15) ? MAX_TASKS : 15;
    localparam int IW        = $clog2(IDX_LIMIT);

    logic [7:0]    r_rem   [STORE];
    logic [7:0]    r_burst [STORE];
    logic [15:0]   r_arr   [STORE];
    logic [7:0]    n_rem   [STORE];
    logic [15:0]   r_time;
    logic [IW-1:0] r_ptr;
    logic [SW-1:0] r_run;
    logic [7:0]    r_slice;
    t_in_item      r_item;
    logic          r_have;
    logic [SW-1:0] r_pick;
    logic [IW-1:0] r_scan_idx;
    logic [3:0]    r_scan_cnt;
    t_out_item     r_out;

    logic [3:0]    n_use;
    logic [IW-1:0] rd_addr;
    logic          rd_ok;
    logic [SW-1:0] rd_sel;
    logic [7:0]    rd_rem;
    logic [15:0]   rd_arr;
    logic          is_tick;
    logic          cont_ok;
    logic [IW-1:0] start;
    logic [4:0]    scan_nxt_w;
    logic [IW-1:0] scan_nxt;
    logic [4:0]    ptr_nxt_w;
    logic [IW-1:0] ptr_nxt;
    logic [15:0]   time_inc;
    logic [7:0]    q_eff;
    logic [7:0]    slice_inc;
    logic          done_now;
    logic          slice_end;
    logic          slot_ok;
    logic          all_done_nx;

    // entries in use
    assign n_use = (i_task_count > 4'(IDX_LIMIT)) ? 4'(IDX_LIMIT) : i_task_count;

    // single table read port, address chosen by phase
    always_comb begin
        unique case (i_cmd.mode)
            MODE_EXEC: rd_addr = IW'(r_run);
            MODE_SCAN: rd_addr = r_scan_idx;
            default:   rd_addr = IW'(r_pick);
        endcase
    end

    assign rd_ok  = (int'(rd_addr) < STORE);
    assign rd_sel = rd_addr[SW-1:0];
    assign rd_rem = rd_ok ? r_rem[rd_sel] : 8'd0;
    assign rd_arr = rd_ok ? r_arr[rd_sel] : 16'd0;

    // open slice check and scan start
    assign is_tick = (r_item.action == ACT_TICK);
    assign cont_ok = (r_slice != 8'd0) && (4'(r_run) < n_use) && (rd_rem != 8'd0);
    assign start   = (4'(r_ptr) < n_use) ? r_ptr : '0;

    // cyclic scan step
    assign scan_nxt_w = 5'(r_scan_idx) + 5'd1;
    assign scan_nxt   = (scan_nxt_w >= 5'(n_use)) ? '0 : scan_nxt_w[IW-1:0];

    assign o_status.is_tick   = is_tick;
    assign o_status.cont_ok   = cont_ok;
    assign o_status.n_zero    = (n_use == 4'd0);
    assign o_status.scan_hit  = rd_ok && (rd_arr <= r_time) && (rd_rem != 8'd0);
    assign o_status.scan_last = (r_scan_cnt == (n_use - 4'd1));

    // tick update terms
    assign time_inc  = (r_time == TIME_MAX) ? r_time : r_time + 16'd1;
    assign q_eff     = (i_quantum == 8'd0) ? 8'd1 : i_quantum;
    assign slice_inc = (r_slice == SLICE_MAX) ? r_slice : r_slice + 8'd1;
    assign done_now  = r_have && (rd_rem == 8'd1);
    assign slice_end = done_now || (slice_inc >= q_eff);
    assign ptr_nxt_w = 5'(r_pick) + 5'd1;
    assign ptr_nxt   = (ptr_nxt_w >= 5'(n_use)) ? '0 : ptr_nxt_w[IW-1:0];
    assign slot_ok   = (int'(r_item.slot) < STORE);

    // remaining work after the transaction, per entry
    always_comb begin
        for (int i = 0; i < STORE; i++) begin
            n_rem[i] = r_rem[i];
            unique case (r_item.action)
                ACT_LOAD: begin
                    if (slot_ok && (int'(r_item.slot) == i)) n_rem[i] = r_item.burst;
                end
                ACT_TICK: begin
                    if (r_have && (int'(r_pick) == i)) n_rem[i] = r_rem[i] - 8'd1;
                end
                ACT_RESTART: n_rem[i] = r_burst[i];
                default: n_rem[i] = r_rem[i];
            endcase
        end
    end

    // every entry in use empty
    always_comb begin
        all_done_nx = 1'b1;
        for (int i = 0; i < STORE; i++) begin
            if ((i < int'(n_use)) && (n_rem[i] != 8'd0)) all_done_nx = 1'b0;
        end
    end

    // input capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_item <= i_item;
        if (i_cmd.commit) begin
            r_out.all_done <= all_done_nx;
            if (is_tick) begin
                r_out.ran_slot        <= r_have ? 3'(r_pick) : 3'd0;
                r_out.idle            <= !r_have;
                r_out.completed       <= done_now;
                r_out.completion_time <= time_inc;
            end else begin
                r_out.ran_slot        <= 3'd0;
                r_out.idle            <= 1'b1;
                r_out.completed       <= 1'b0;
                r_out.completion_time <= (r_item.action == ACT_RESTART) ? 16'd0 : r_time;
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.mode == MODE_EXEC) begin
            r_pick <= r_run;
            if (is_tick && !cont_ok) begin
                r_scan_idx <= start;
                r_scan_cnt <= 4'd0;
            end
        end else if (i_cmd.mode == MODE_SCAN) begin
            if (o_status.scan_hit) r_pick <= rd_sel;
            r_scan_idx <= scan_nxt;
            r_scan_cnt <= r_scan_cnt + 4'd1;
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE; i++) begin
                r_rem[i]   <= 8'd0;
                r_burst[i] <= 8'd0;
                r_arr[i]   <= 16'd0;
            end
            r_time  <= 16'd0;
            r_ptr   <= '0;
            r_run   <= '0;
            r_slice <= 8'd0;
            r_have  <= 1'b0;
        end else begin
            if (i_cmd.mode == MODE_EXEC) begin
                r_have <= is_tick && cont_ok;
                // a fresh scan always drops the old slice
                if (is_tick && !cont_ok) r_slice <= 8'd0;
            end else if ((i_cmd.mode == MODE_SCAN) && o_status.scan_hit) begin
                r_have <= 1'b1;
            end
            if (i_cmd.commit) begin
                for (int i = 0; i < STORE; i++) r_rem[i] <= n_rem[i];
                unique case (r_item.action)
                    ACT_LOAD: begin
                        if (slot_ok) begin
                            r_burst[r_item.slot[SW-1:0]] <= r_item.burst;
                            r_arr[r_item.slot[SW-1:0]]   <= r_item.arrival;
                        end
                    end
                    ACT_TICK: begin
                        r_time <= time_inc;
                        if (r_have) begin
                            r_run   <= r_pick;
                            r_slice <= slice_end ? 8'd0 : slice_inc;
                            if (slice_end) r_ptr <= ptr_nxt;
                        end
                    end
                    ACT_RESTART: begin
                        r_time  <= 16'd0;
                        r_ptr   <= '0;
                        r_run   <= '0;
                        r_slice <= 8'd0;
                    end
                    default: r_time <= r_time;
                endcase
            end
        end
    end

    assign o_result = r_out;

endmodule

// ===== rtl/round_robin_time_slice_scheduler.sv =====
`timescale 1ns / 1ps

// Round-robin time-slice scheduler over a table of up to eight tasks. Each input
// transaction loads one task entry, advances time by one tick, or restarts the run
// (an unused action code changes nothing), and gives exactly one result transaction.
// Loads, restarts and ticks that continue an open slice pass through the EXEC and
// COMMIT states. A tick that opens a new slice also passes through SCAN, where the
// cyclic ready search reads one entry per cycle through the single table read port
// until a ready task or the last entry in use. COMMIT waits for a free output
// register. A new transaction is accepted once the previous result is in the output
// register, while that result may still wait to be taken. Configuration: quantum at
// byte address 0, task_count at byte address 4; write only while the block is idle.

module round_robin_time_slice_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrts_in_if.sink     i_in,
    rrts_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rrts_pkg::*;

    logic [7:0] r_quantum;
    logic [3:0] r_task_count;
    logic       cfg_wr;
    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum    <= 8'd2;
            r_task_count <= 4'd8;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_QUANTUM:    r_quantum    <= pwdata[7:0];
                REG_TASK_COUNT: r_task_count <= pwdata[3:0];
                default:        r_quantum    <= r_quantum;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_QUANTUM:    prdata = 32'(r_quantum);
            REG_TASK_COUNT: prdata = 32'(r_task_count);
            default:        prdata = 32'd0;
        endcase
    end

    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rrts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_quantum    (r_quantum),
        .i_task_count (r_task_count),
        .i_item       (i_in.data),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_result     (o_out.data)
    );

    // busy right after a transaction is taken in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready while a transaction is in progress");

    // a new result only comes out of a transaction in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result appeared without a transaction in progress");

    // an idle tick never completes a task
    a_idle_not_completed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.data.idle && o_out.data.completed))
        else $error("idle result flagged as completed");

endmodule

// ===== dv/round_robin_time_slice_scheduler_tb.sv =====
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_tb;
    import rrts_pkg::*;

    localparam int         TASK_SLOTS      = 8;
    localparam logic [1:0] ACT_BAD         = 2'd3;
    localparam logic [2:0] ADDR_QUANTUM    = {REG_QUANTUM, 2'b00};
    localparam logic [2:0] ADDR_TASK_COUNT = {REG_TASK_COUNT, 2'b00};
    localparam int         HOLD_CYCLES     = 300;
    localparam int         NUM_PHASES      = 12;
    localparam int         PHASE_ITEMS     = 46;

    // per-phase settings, -1 picks a random value
    localparam int PH_QUANTUM [NUM_PHASES] = '{2, 1, 255, 0, 3, 1, 4, 2, -1, -1, 1, 3};
    localparam int PH_TASKS   [NUM_PHASES] = '{8, 3, 8, 15, 1, 8, 2, 0, -1, 8, 5, 8};

    typedef struct {
        bit        cfg;
        int        q;
        int        tc;
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rrts_in_if  in_ch ();
    rrts_out_if out_ch ();

    round_robin_time_slice_scheduler dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scheduler image kept by the testbench
    logic [7:0]  work_left  [TASK_SLOTS];
    logic [7:0]  work_total [TASK_SLOTS];
    logic [15:0] ready_time [TASK_SLOTS];
    logic [15:0] sched_time;
    logic [2:0]  next_ptr;
    logic [2:0]  run_slot;
    logic [7:0]  slice_cnt;
    logic [7:0]  cfg_quantum;
    logic [3:0]  cfg_task_count;

    t_out_item pending_results [$];
    t_dir_row  dir_rows [$];
    int        mismatch_count = 0;
    bit        quiet    = 1'b0;
    bit        hold_req = 1'b0;

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin : watchdog
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int tasks_in_use();
        return (cfg_task_count > TASK_SLOTS) ? TASK_SLOTS : int'(cfg_task_count);
    endfunction

    function automatic bit tasks_finished();
        bit fin;
        fin = 1'b1;
        for (int i = 0; i < tasks_in_use(); i++) begin
            if (work_left[i] != 0) fin = 1'b0;
        end
        return fin;
    endfunction

    // expected result of one accepted transaction, advances the image
    function automatic t_out_item predict_schedule(input t_in_item it);
        t_out_item  res;
        int         n;
        int         start;
        int         c;
        int         pick;
        bit         have;
        logic [7:0] q;
        res      = '0;
        res.idle = 1'b1;
        n        = tasks_in_use();
        have     = 1'b0;
        pick     = 0;
        case (it.action)
            ACT_LOAD: begin
                work_left[it.slot]  = it.burst;
                work_total[it.slot] = it.burst;
                ready_time[it.slot] = it.arrival;
            end
            ACT_RESTART: begin
                for (int i = 0; i < TASK_SLOTS; i++) work_left[i] = work_total[i];
                sched_time = '0;
                next_ptr   = '0;
                run_slot   = '0;
                slice_cnt  = '0;
            end
            ACT_TICK: begin
                // keep the open slice, else scan cyclically for a ready task
                if (slice_cnt != 0 && int'(run_slot) < n && work_left[run_slot] != 0) begin
                    have = 1'b1;
                    pick = run_slot;
                end else begin
                    start     = (int'(next_ptr) < n) ? int'(next_ptr) : 0;
                    slice_cnt = '0;
                    for (int i = 0; i < n; i++) begin
                        c = start + i;
                        if (c >= n) c -= n;
                        if (!have && ready_time[c] <= sched_time && work_left[c] != 0) begin
                            have = 1'b1;
                            pick = c;
                        end
                    end
                end
                if (sched_time != TIME_MAX) sched_time++;
                if (have) begin
                    q            = (cfg_quantum == 0) ? 8'd1 : cfg_quantum;
                    res.idle     = 1'b0;
                    res.ran_slot = 3'(pick);
                    run_slot     = 3'(pick);
                    work_left[pick]--;
                    if (slice_cnt != SLICE_MAX) slice_cnt++;
                    if (work_left[pick] == 0) res.completed = 1'b1;
                    if (res.completed || slice_cnt >= q) begin
                        slice_cnt = '0;
                        next_ptr  = (pick + 1 >= n) ? 3'd0 : 3'(pick + 1);
                    end
                end
            end
            default: begin
                // unknown action leaves everything alone
            end
        endcase
        res.completion_time = sched_time;
        res.all_done        = tasks_finished();
        return res;
    endfunction

    function automatic t_in_item pack_item(input logic [1:0] act, input int slot,
                                           input int burst, input int arr);
        t_in_item it;
        it.action  = act;
        it.slot    = 3'(slot);
        it.burst   = 8'(burst);
        it.arrival = 16'(arr);
        return it;
    endfunction

    function automatic t_dir_row drow(input bit cfg, input int q, input int tc,
                                      input logic [1:0] act, input int slot, input int burst,
                                      input int arr, input bit typed, input int ran,
                                      input int idl, input int comp, input int tm,
                                      input int ad);
        t_dir_row r;
        r.cfg                  = cfg;
        r.q                    = q;
        r.tc                   = tc;
        r.it                   = pack_item(act, slot, burst, arr);
        r.typed                = typed;
        r.want.ran_slot        = 3'(ran);
        r.want.idle            = 1'(idl);
        r.want.completed       = 1'(comp);
        r.want.completion_time = 16'(tm);
        r.want.all_done        = 1'(ad);
        return r;
    endfunction

    // mostly short bursts, now and then the full range
    function automatic logic [7:0] pick_burst();
        int r;
        r = $urandom_range(0, 49);
        if (r < 45) return 8'($urandom_range(1, 6));
        if (r < 49) return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    endfunction

    // mostly near the current time, sometimes far off
    function automatic logic [15:0] pick_arrival();
        int r;
        int lim;
        lim = int'(sched_time) + 16;
        if (lim > 65535) lim = 65535;
        r = $urandom_range(0, 19);
        if (r < 14) return 16'($urandom_range(0, lim));
        if (r < 18) return 16'($urandom_range(0, 65535));
        return TIME_MAX;
    endfunction

    function automatic t_in_item make_item(input int n_use);
        t_in_item it;
        int       r;
        int       top;
        top = (n_use > 0) ? n_use - 1 : 0;
        it  = pack_item(ACT_TICK, $urandom_range(0, 7), $urandom_range(0, 255),
                        $urandom_range(0, 65535));
        r   = $urandom_range(0, 99);
        if (r < 74) begin
            // once everything is done a restart starts the next round
            if (tasks_finished() && $urandom_range(0, 2) == 0) it.action = ACT_RESTART;
        end else if (r < 88) begin
            it.action  = ACT_LOAD;
            it.slot    = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(0, top))
                                                     : 3'($urandom_range(0, 7));
            it.burst   = pick_burst();
            it.arrival = pick_arrival();
        end else if (r < 95) begin
            it.action = ACT_RESTART;
        end else begin
            it.action = ACT_BAD;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // offer one transaction and record its expected result on acceptance
    task automatic send_item(input t_in_item it, input bit use_want, input t_out_item want);
        t_out_item predicted;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predicted = predict_schedule(it);
        pending_results.push_back(use_want ? want : predicted);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(input int q_val, input int tc_val);
        drain();
        apb_write(ADDR_QUANTUM, 32'(q_val));
        apb_write(ADDR_TASK_COUNT, 32'(tc_val));
        cfg_quantum    = 8'(q_val);
        cfg_task_count = 4'(tc_val);
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin : result_sink
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk) begin : result_check
        t_out_item got;
        t_out_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot %0d idle %0b time %0d",
                                          got.ran_slot, got.idle, got.completion_time));
            end else begin
                want = pending_results.pop_front();
                if (got.ran_slot !== want.ran_slot || got.idle !== want.idle ||
                    got.completed !== want.completed ||
                    got.completion_time !== want.completion_time ||
                    got.all_done !== want.all_done) begin
                    report_mismatch($sformatf(
                        "got slot %0d idle %0b done %0b time %0d all %0b, want %0d %0b %0b %0d %0b",
                        got.ran_slot, got.idle, got.completed, got.completion_time, got.all_done,
                        want.ran_slot, want.idle, want.completed, want.completion_time,
                        want.all_done));
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int n_use;
        int q_set;
        int tc_set;
        int wait_cnt;

        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;

        for (int i = 0; i < TASK_SLOTS; i++) begin
            work_left[i]  = '0;
            work_total[i] = '0;
            ready_time[i] = '0;
        end
        sched_time     = '0;
        next_ptr       = '0;
        run_slot       = '0;
        slice_cnt      = '0;
        cfg_quantum    = 8'd2;
        cfg_task_count = 4'd8;

        // directed rows: cfg q tc | action slot burst arrival | typed slot idle done time all
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 1, 0, 1, 0, 1, 1));
        dir_rows.push_back(drow(0, 0, 0, ACT_BAD,     7, 255, 65535, 1, 0, 1, 0, 1, 1));
        dir_rows.push_back(drow(0, 0, 0, ACT_LOAD,    0,   3,     0, 1, 0, 1, 0, 1, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_LOAD,    7, 255, 65535, 1, 0, 1, 0, 1, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_LOAD,    3,   0,     0, 1, 0, 1, 0, 1, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 1, 0, 0, 0, 2, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 1, 0, 0, 0, 3, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_LOAD,    5,   1,     2, 1, 0, 1, 0, 3, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 1, 5, 0, 1, 4, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 1, 0, 0, 1, 5, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 1, 0, 1, 0, 6, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_LOAD,    0,   2,     0, 1, 0, 1, 0, 6, 0));
        // reload of the running task in the middle of its slice
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_LOAD,    0,   4,     0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_RESTART, 0,   0,     0, 1, 0, 1, 0, 0, 0));
        // empty table in use, then count above the table size with quantum zero
        dir_rows.push_back(drow(1, 0, 0, ACT_TICK,    0,   0,     0, 1, 0, 1, 0, 1, 1));
        dir_rows.push_back(drow(1, 0, 15, ACT_TICK,   0,   0,     0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 0, 0, 0, 0, 0, 0));
        // pointer beyond the entries in use, then a slice left without work
        dir_rows.push_back(drow(1, 255, 1, ACT_TICK,  0,   0,     0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_LOAD,    0,   0,     0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(0, 0, 0, ACT_TICK,    0,   0,     0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(drow(1, 2, 8, ACT_TICK,    6, 200, 40000, 0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg) write_config(dir_rows[r].q, dir_rows[r].tc);
            send_item(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases, each one a fresh table and restart
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            q_set  = (PH_QUANTUM[ph] < 0) ? int'($urandom_range(0, 255)) : PH_QUANTUM[ph];
            tc_set = (PH_TASKS[ph] < 0) ? int'($urandom_range(0, 15)) : PH_TASKS[ph];
            if (ph >= NUM_PHASES - 2) quiet = 1'b1;
            write_config(q_set, tc_set);
            if (ph == 2) hold_req = 1'b1;
            n_use = tasks_in_use();
            for (int s = 0; s < n_use; s++) begin
                send_item(pack_item(ACT_LOAD, s, pick_burst(), pick_arrival()), 1'b0, '0);
            end
            send_item(pack_item(ACT_RESTART, 0, 0, 0), 1'b0, '0);
            for (int k = n_use + 1; k < PHASE_ITEMS; k++) begin
                if (ph == 5 && k == 20) drain();
                send_item(make_item(n_use), 1'b0, '0);
            end
        end

        // drain and finish
        in_ch.valid <= 1'b0;
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 5000) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
